/* src/crcrd_pkg.sv */
// Package: shared types, codes and the CRC16 byte update for the reply deframer.
`timescale 1ns / 1ps

package crcrd_pkg;

    localparam logic [7:0] START_BYTE = 8'h2E;

    // Frame parser phases
    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_ACK     = 3'd3,
        PH_CRC_HI  = 3'd4,
        PH_CRC_LO  = 3'd5
    } phase_t;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
    localparam logic [1:0] KIND_FRAME_END = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT   = 2'd2;

    // Phase reported with a timeout abort
    localparam logic [1:0] TP_HUNT    = 2'd0;
    localparam logic [1:0] TP_HEADER  = 2'd1;
    localparam logic [1:0] TP_PAYLOAD = 2'd2;
    localparam logic [1:0] TP_TAIL    = 2'd3;

    // Input op codes
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [7:0]  command_code;
        logic [15:0] frame_address;
        logic [7:0]  ack_code;
        logic        crc_ok;
        logic        crc_form;
        logic [1:0]  timeout_phase;
    } result_t;

    // CRC16-XMODEM: poly 0x1021, MSB first, one byte per call
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ 16'h1021;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* src/crcrd_if.sv */
// Interfaces: received-byte channel, result channel and configuration write channel.
`timescale 1ns / 1ps

interface crcrd_byte_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface crcrd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  command_code;
    logic [15:0] frame_address;
    logic [7:0]  ack_code;
    logic        crc_ok;
    logic        crc_form;
    logic [1:0]  timeout_phase;

    modport source (output valid, output kind, output payload_byte, output payload_index,
                    output command_code, output frame_address, output ack_code,
                    output crc_ok, output crc_form, output timeout_phase, input ready);
    modport sink   (input valid, input kind, input payload_byte, input payload_index,
                    input command_code, input frame_address, input ack_code,
                    input crc_ok, input crc_form, input timeout_phase, output ready);
endinterface

interface crcrd_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/crc_checked_reply_deframer_top.sv */
// Reply deframer: hunts for 0x2E, parses header/payload/ack/CRC, checks CRC16-XMODEM.
//
// Usage:
//   byte_ch   : one word per received byte (op = 0) or a receive timeout (op = 1).
//   result_ch : payload words stream out as they arrive (kind 0); the last CRC
//               byte gives one frame-end word (kind 1) with header, ack, crc_ok
//               and crc_form; a timeout gives an abort word (kind 2) with the
//               phase it hit, and the parser goes back to hunting.
//   cfg_ch    : writes allow_ack_in_crc (reset 1); write only while idle.
// Path: a word accepted from byte_ch lands in the input register, is parsed
//   from there and its result is held in the result register for result_ch.
// Throughput: one word per cycle while the result register is free; the CRC byte
//   update is one short combinational step between the input register and crc_reg.
// Reset: parser hunts for the start byte, both stages empty, option set.
// Stall: the result register holds while result_ch.ready is low; the input
//   register then fills and byte_ch.ready drops until the result is taken.
//   Words that give no result still need a free result slot to advance.
`timescale 1ns / 1ps

module crc_checked_reply_deframer_top (
    input  logic                  clk,
    input  logic                  rst_n,
    crcrd_byte_if.sink            byte_ch,
    crcrd_result_if.source        result_ch,
    crcrd_cfg_if.sink             cfg_ch
);
    import crcrd_pkg::*;

    // input register
    logic        s1_valid_reg;
    logic        s1_op_reg;
    logic [7:0]  s1_byte_reg;

    // result register
    logic        out_valid_reg;
    result_t     result_reg;
    result_t     result_next;
    logic        res_fire;

    // parser state
    phase_t      phase_reg, phase_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  len_m1_reg, len_m1_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  ack_reg, ack_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] crc_ack_reg, crc_ack_next;
    logic [7:0]  crc_hi_reg, crc_hi_next;
    logic        allow_reg;

    logic        out_free;
    logic        s1_go;
    logic [15:0] crc_upd;
    logic [15:0] rx_crc;
    logic        ok0;
    logic        ok1;

    assign out_free     = !out_valid_reg || result_ch.ready;
    assign s1_go        = s1_valid_reg && out_free;
    assign byte_ch.ready = !s1_valid_reg || s1_go;
    assign cfg_ch.ready = 1'b1;

    assign crc_upd = crc16_step(crc_reg, s1_byte_reg);
    assign rx_crc  = {crc_hi_reg, s1_byte_reg};
    assign ok0     = (crc_reg == rx_crc);
    assign ok1     = allow_reg && (crc_ack_reg == rx_crc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (byte_ch.ready)
        begin
            s1_valid_reg <= byte_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ch.valid && byte_ch.ready)
        begin
            s1_op_reg   <= byte_ch.op;
            s1_byte_reg <= byte_ch.rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_reg <= 1'b1;
        end
        else if (cfg_ch.valid)
        begin
            allow_reg <= cfg_ch.data;
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            if (out_free)
                out_valid_reg <= res_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        len_m1_reg  <= len_m1_next;
        cmd_reg     <= cmd_next;
        addr_reg    <= addr_next;
        ack_reg     <= ack_next;
        crc_reg     <= crc_next;
        crc_ack_reg <= crc_ack_next;
        crc_hi_reg  <= crc_hi_next;
        if (out_free && res_fire)
            result_reg <= result_next;
    end

    // next state and result
    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        len_m1_next  = len_m1_reg;
        cmd_next     = cmd_reg;
        addr_next    = addr_reg;
        ack_next     = ack_reg;
        crc_next     = crc_reg;
        crc_ack_next = crc_ack_reg;
        crc_hi_next  = crc_hi_reg;
        res_fire     = 1'b0;
        result_next  = '0;

        if (s1_go)
        begin
            if (s1_op_reg == OP_TIMEOUT)
            begin
                res_fire           = 1'b1;
                result_next.kind   = KIND_TIMEOUT;
                unique case (phase_reg)
                    PH_HUNT:    result_next.timeout_phase = TP_HUNT;
                    PH_HEADER:  result_next.timeout_phase = TP_HEADER;
                    PH_PAYLOAD: result_next.timeout_phase = TP_PAYLOAD;
                    default:    result_next.timeout_phase = TP_TAIL;
                endcase
                phase_next = PH_HUNT;
                count_next = '0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        crc_next   = crc_upd;
                        count_next = count_reg + 8'd1;
                        case (count_reg[1:0])
                            2'd0: cmd_next = s1_byte_reg;
                            2'd1: addr_next = {s1_byte_reg, addr_reg[7:0]};
                            2'd2: addr_next = {addr_reg[15:8], s1_byte_reg};
                            default:
                            begin
                                // length 0 means 256, kept as length - 1
                                len_m1_next = s1_byte_reg - 8'd1;
                                phase_next  = PH_PAYLOAD;
                                count_next  = '0;
                            end
                        endcase
                    end
                    PH_PAYLOAD:
                    begin
                        crc_next                  = crc_upd;
                        res_fire                  = 1'b1;
                        result_next.kind          = KIND_PAYLOAD;
                        result_next.payload_byte  = s1_byte_reg;
                        result_next.payload_index = count_reg;
                        count_next                = count_reg + 8'd1;
                        if (count_reg == len_m1_reg)
                        begin
                            phase_next = PH_ACK;
                            count_next = '0;
                        end
                    end
                    PH_ACK:
                    begin
                        ack_next     = s1_byte_reg;
                        crc_ack_next = crc_upd;
                        phase_next   = PH_CRC_HI;
                    end
                    PH_CRC_HI:
                    begin
                        crc_hi_next = s1_byte_reg;
                        phase_next  = PH_CRC_LO;
                    end
                    PH_CRC_LO:
                    begin
                        res_fire                  = 1'b1;
                        result_next.kind          = KIND_FRAME_END;
                        result_next.command_code  = cmd_reg;
                        result_next.frame_address = addr_reg;
                        result_next.ack_code      = ack_reg;
                        result_next.crc_ok        = ok0 || ok1;
                        result_next.crc_form      = !ok0 && ok1;
                        phase_next                = PH_HUNT;
                        count_next                = '0;
                    end
                    default:
                    begin
                        // hunting, and any unused phase code
                        if (s1_byte_reg == START_BYTE)
                        begin
                            crc_next   = crc16_step(16'h0000, s1_byte_reg);
                            phase_next = PH_HEADER;
                            count_next = '0;
                        end
                        else
                        begin
                            phase_next = PH_HUNT;
                        end
                    end
                endcase
            end
        end
    end

    assign result_ch.valid         = out_valid_reg;
    assign result_ch.kind          = result_reg.kind;
    assign result_ch.payload_byte  = result_reg.payload_byte;
    assign result_ch.payload_index = result_reg.payload_index;
    assign result_ch.command_code  = result_reg.command_code;
    assign result_ch.frame_address = result_reg.frame_address;
    assign result_ch.ack_code      = result_reg.ack_code;
    assign result_ch.crc_ok        = result_reg.crc_ok;
    assign result_ch.crc_form      = result_reg.crc_form;
    assign result_ch.timeout_phase = result_reg.timeout_phase;

endmodule

/* src/crcrd_checker.sv */
// Checker: port-level properties of the reply deframer, bound to the top level.
`timescale 1ns / 1ps

module crcrd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [1:0]  result_kind,
    input  logic [7:0]  result_payload_byte,
    input  logic [15:0] result_frame_address,
    input  logic        result_crc_ok,
    input  logic        result_crc_form,
    input  logic [1:0]  result_timeout_phase
);
    import crcrd_pkg::*;

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_kind) && $stable(result_payload_byte)
            && $stable(result_crc_ok))
        else $error("result word changed while stalled");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            (result_kind == KIND_PAYLOAD || result_kind == KIND_FRAME_END
             || result_kind == KIND_TIMEOUT))
        else $error("invalid result kind");

    a_form: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_crc_form |->
            result_crc_ok && result_kind == KIND_FRAME_END)
        else $error("crc_form set without a matching frame end");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind == KIND_PAYLOAD |->
            !result_crc_ok && result_timeout_phase == TP_HUNT
            && result_frame_address == 16'h0000)
        else $error("payload word carries frame-end or timeout fields");

endmodule

bind crc_checked_reply_deframer_top crcrd_checker u_crcrd_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .result_valid         (result_ch.valid),
    .result_ready         (result_ch.ready),
    .result_kind          (result_ch.kind),
    .result_payload_byte  (result_ch.payload_byte),
    .result_frame_address (result_ch.frame_address),
    .result_crc_ok        (result_ch.crc_ok),
    .result_crc_form      (result_ch.crc_form),
    .result_timeout_phase (result_ch.timeout_phase)
);
